>>> src/acm_pkg.sv
`timescale 1ns / 1ps

package acm_pkg;

  // Number of class positions the confusion store is built for.
  localparam int MAX_CLASSES = 16;
  // Position and predicted class: 0 .. MAX_CLASSES, where MAX_CLASSES means none.
  localparam int POS_W = $clog2(MAX_CLASSES + 1);
  // Row or column index of one confusion cell.
  localparam int IDX_W = $clog2(MAX_CLASSES);
  localparam int CELL_W = 2 * IDX_W;
  localparam int CELLS = MAX_CLASSES * MAX_CLASSES;

  // Field widths that are fixed by the interface.
  localparam int CLASS_W = 5;
  localparam int LABEL_W = 4;
  localparam int RESULT_W = 32;

  localparam logic [CLASS_W-1:0] NUM_CLASSES_RESET = CLASS_W'(MAX_CLASSES);

  // Register index as decoded from the APB address.
  localparam logic REG_NUM_CLASSES = 1'b0;

  typedef enum logic {
    OP_SCORE = 1'b0,
    OP_READ  = 1'b1
  } acm_op_t;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_CELL    = 1'b1
  } acm_kind_t;

  typedef enum logic {
    ST_OK      = 1'b0,
    ST_UNKNOWN = 1'b1
  } acm_status_t;

  // One result request handed from the argmax stage to the store stage.
  typedef struct packed {
    acm_kind_t         kind;
    logic [POS_W-1:0]  pred;
    acm_status_t       status;
    logic              hit;
    logic              bump;
    logic [CELL_W-1:0] addr;
  } acm_req_t;

endpackage

>>> src/acm_stream_if.sv
`timescale 1ns / 1ps

// Input channel: score elements and cell read requests.
interface acm_in_if #(
  parameter int SCORE_BITS = 16
) ();
  import acm_pkg::*;

  logic                         valid;
  logic                         ready;
  acm_op_t                      opcode;
  logic signed [SCORE_BITS-1:0] score;
  logic                         score_not_finite;
  logic                         last_of_sample;
  logic [LABEL_W-1:0]           true_label;
  logic [LABEL_W-1:0]           cell_row;
  logic [LABEL_W-1:0]           cell_col;

  modport source (
    output valid, opcode, score, score_not_finite, last_of_sample,
           true_label, cell_row, cell_col,
    input  ready
  );

  modport sink (
    input  valid, opcode, score, score_not_finite, last_of_sample,
           true_label, cell_row, cell_col,
    output ready
  );

  modport monitor (
    input valid, ready, opcode, score, score_not_finite, last_of_sample,
          true_label, cell_row, cell_col
  );
endinterface

// Output channel: sample verdicts and cell read data.
interface acm_out_if ();
  import acm_pkg::*;

  logic                valid;
  logic                ready;
  acm_kind_t           result_kind;
  logic [CLASS_W-1:0]  predicted_class;
  acm_status_t         status;
  logic                hit;
  logic [RESULT_W-1:0] samples_seen;
  logic [RESULT_W-1:0] correct_seen;
  logic [RESULT_W-1:0] cell_value;

  modport source (
    output valid, result_kind, predicted_class, status, hit,
           samples_seen, correct_seen, cell_value,
    input  ready
  );

  modport sink (
    input  valid, result_kind, predicted_class, status, hit,
           samples_seen, correct_seen, cell_value,
    output ready
  );

  modport monitor (
    input valid, ready, result_kind, predicted_class, status, hit,
          samples_seen, correct_seen, cell_value
  );
endinterface

>>> src/acm_argmax.sv
`timescale 1ns / 1ps

module acm_argmax #(
  parameter int SCORE_BITS = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  acm_pkg::acm_op_t               opcode,
  input  logic signed [SCORE_BITS-1:0]   score,
  input  logic                           score_not_finite,
  input  logic                           last_of_sample,
  input  logic [acm_pkg::LABEL_W-1:0]    true_label,
  input  logic [acm_pkg::LABEL_W-1:0]    cell_row,
  input  logic [acm_pkg::LABEL_W-1:0]    cell_col,
  input  logic [acm_pkg::CLASS_W-1:0]    num_classes,
  output logic                           req_valid,
  output acm_pkg::acm_req_t              req,
  output logic [COUNT_BITS-1:0]          samples_next,
  output logic [COUNT_BITS-1:0]          correct_next
);
  import acm_pkg::*;

  localparam logic [POS_W-1:0] POS_NONE = POS_W'(MAX_CLASSES);

  // Running argmax of the sample in progress and the sample counters.
  logic signed [SCORE_BITS-1:0] best_score, best_score_next;
  logic [POS_W-1:0]             best_pos, best_pos_next;
  logic [POS_W-1:0]             pos, pos_next;
  logic [COUNT_BITS-1:0]        samples, correct;

  logic                         take;
  logic                         wins;
  logic [POS_W-1:0]             pred;
  logic [CLASS_W-1:0]           classes_used;
  logic                         unknown;
  logic                         match;
  logic                         bad_cell;

  // A finite element inside the store range wins on a strict increase or
  // when nothing finite has been seen yet.
  assign take = !score_not_finite && (pos < POS_NONE);
  assign wins = take && ((best_pos >= POS_NONE) || (score > best_score));
  assign pred = wins ? pos : best_pos;

  assign classes_used = (num_classes > CLASS_W'(MAX_CLASSES)) ?
                        CLASS_W'(MAX_CLASSES) : num_classes;
  assign unknown = (CLASS_W'(pred) >= classes_used) ||
                   (CLASS_W'(true_label) >= classes_used);
  assign match = (pred == POS_W'(true_label));
  assign bad_cell = (CLASS_W'(cell_row) >= CLASS_W'(MAX_CLASSES)) ||
                    (CLASS_W'(cell_col) >= CLASS_W'(MAX_CLASSES));

  // Next argmax state, counters and the request for the store stage.
  always_comb begin
    best_score_next = best_score;
    best_pos_next   = best_pos;
    pos_next        = pos;
    samples_next    = samples;
    correct_next    = correct;
    req_valid       = 1'b0;
    req             = '0;
    case (opcode)
      OP_READ: begin
        req_valid  = 1'b1;
        req.kind   = KIND_CELL;
        req.status = bad_cell ? ST_UNKNOWN : ST_OK;
        req.addr   = {cell_row[IDX_W-1:0], cell_col[IDX_W-1:0]};
      end
      default: begin
        if (wins) begin
          best_score_next = score;
          best_pos_next   = pos;
        end
        if (pos < POS_NONE) begin
          pos_next = pos + 1'b1;
        end
        if (last_of_sample) begin
          req_valid       = 1'b1;
          req.kind        = KIND_VERDICT;
          req.pred        = pred;
          req.status      = unknown ? ST_UNKNOWN : ST_OK;
          req.hit         = !unknown && match;
          req.bump        = !unknown;
          req.addr        = {true_label[IDX_W-1:0], pred[IDX_W-1:0]};
          if (!unknown) begin
            samples_next = (samples == '1) ? samples : samples + 1'b1;
            if (match) begin
              correct_next = (correct == '1) ? correct : correct + 1'b1;
            end
          end
          best_score_next = '0;
          best_pos_next   = POS_NONE;
          pos_next        = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score <= '0;
      best_pos   <= POS_NONE;
      pos        <= '0;
      samples    <= '0;
      correct    <= '0;
    end else if (accept) begin
      best_score <= best_score_next;
      best_pos   <= best_pos_next;
      pos        <= pos_next;
      samples    <= samples_next;
      correct    <= correct_next;
    end
  end

endmodule

>>> src/acm_cell_store.sv
`timescale 1ns / 1ps

module acm_cell_store #(
  parameter int COUNT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [acm_pkg::CELL_W-1:0]   rd_addr,
  input  logic                         bump,
  output logic [COUNT_BITS-1:0]        cur_value
);
  import acm_pkg::*;

  // Confusion counts, one synchronous read port and one write port.
  logic [COUNT_BITS-1:0] mem [CELLS];
  logic [CELLS-1:0]      filled;

  logic [COUNT_BITS-1:0] mem_q;
  logic                  filled_q;
  logic [CELL_W-1:0]     addr_q;

  // Most recent write, forwarded when the held read targets the same cell.
  logic                  fwd_valid;
  logic [CELL_W-1:0]     fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;

  logic [COUNT_BITS-1:0] inc_value;

  // A cell that was never written reads as zero.
  assign cur_value = (fwd_valid && (fwd_addr == addr_q)) ? fwd_data :
                     (filled_q ? mem_q : '0);
  assign inc_value = (cur_value == '1) ? cur_value : cur_value + 1'b1;

  // Memory array: write back the saturated count of the held cell.
  always_ff @(posedge clk) begin
    if (bump) begin
      mem[addr_q] <= inc_value;
    end
    if (rd_en) begin
      mem_q  <= mem[rd_addr];
      addr_q <= rd_addr;
    end
    if (bump) begin
      fwd_addr <= addr_q;
      fwd_data <= inc_value;
    end
  end

  // Valid bits and forwarding control.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      filled_q  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (bump) begin
        filled[addr_q] <= 1'b1;
        fwd_valid      <= 1'b1;
      end
      if (rd_en) begin
        filled_q <= filled[rd_addr];
      end
    end
  end

endmodule

>>> src/argmax_confusion_matrix_top.sv
`timescale 1ns / 1ps

// Argmax classifier with a confusion matrix. Score elements of a sample stream in on
// sample_in, one transaction per cycle while the output is not stalled; the block keeps
// a running strict maximum, and on the element marked last it emits a verdict and, when
// the class and label are in range, bumps the sample, correct and confusion counters,
// all saturating. A read opcode returns one confusion cell with the current counters.
// A verdict or read is delivered through a store stage that does one read-modify-write
// of the confusion memory per transaction (the last write is forwarded, so back-to-back
// bumps of one cell are exact) and then an output register. Elements that are not last
// produce no result. The confusion store is cleared at reset by per-cell valid bits, so
// no clearing pass is needed. num_classes is an APB register at address 0; the user must
// write it only while the block is idle, and the block itself does not enforce this.
module argmax_confusion_matrix_top #(
  parameter int SCORE_BITS = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  acm_in_if.sink       sample_in,
  acm_out_if.source    result_out,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import acm_pkg::*;

  // Configuration register.
  logic [CLASS_W-1:0] num_classes;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NUM_CLASSES) ? 32'(num_classes) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= NUM_CLASSES_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NUM_CLASSES)) begin
      num_classes <= pwdata[CLASS_W-1:0];
    end
  end

  // Handshake of the two stages.
  logic                  in_fire;
  logic                  s1_valid;
  logic                  s1_adv;
  logic                  out_valid;

  assign s1_adv          = !out_valid || result_out.ready;
  assign sample_in.ready = !s1_valid || s1_adv;
  assign in_fire         = sample_in.valid && sample_in.ready;

  // Argmax and counter stage.
  logic                  req_valid;
  acm_req_t              req;
  logic [COUNT_BITS-1:0] samples_next;
  logic [COUNT_BITS-1:0] correct_next;

  acm_argmax #(
    .SCORE_BITS (SCORE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_argmax (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_fire),
    .opcode           (sample_in.opcode),
    .score            (sample_in.score),
    .score_not_finite (sample_in.score_not_finite),
    .last_of_sample   (sample_in.last_of_sample),
    .true_label       (sample_in.true_label),
    .cell_row         (sample_in.cell_row),
    .cell_col         (sample_in.cell_col),
    .num_classes      (num_classes),
    .req_valid        (req_valid),
    .req              (req),
    .samples_next     (samples_next),
    .correct_next     (correct_next)
  );

  // Store stage register.
  acm_req_t              s1_req;
  logic [COUNT_BITS-1:0] s1_samples;
  logic [COUNT_BITS-1:0] s1_correct;
  logic [COUNT_BITS-1:0] cur_value;
  logic                  s1_load;

  assign s1_load = in_fire && req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_in.ready) begin
      s1_valid <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_req     <= req;
      s1_samples <= samples_next;
      s1_correct <= correct_next;
    end
  end

  acm_cell_store #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cell_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (s1_load),
    .rd_addr   (req.addr),
    .bump      (s1_valid && s1_adv && s1_req.bump),
    .cur_value (cur_value)
  );

  // Output register, counters brought to the result width.
  logic [63:0]           samples_wide;
  logic [63:0]           correct_wide;
  logic [63:0]           cell_wide;
  logic [COUNT_BITS-1:0] cell_shown;

  assign cell_shown   = ((s1_req.kind == KIND_CELL) && (s1_req.status == ST_OK)) ?
                        cur_value : '0;
  assign samples_wide = 64'(s1_samples);
  assign correct_wide = 64'(s1_correct);
  assign cell_wide    = 64'(cell_shown);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      result_out.result_kind     <= s1_req.kind;
      result_out.predicted_class <= CLASS_W'(s1_req.pred);
      result_out.status          <= s1_req.status;
      result_out.hit             <= s1_req.hit;
      result_out.samples_seen    <= samples_wide[RESULT_W-1:0];
      result_out.correct_seen    <= correct_wide[RESULT_W-1:0];
      result_out.cell_value      <= cell_wide[RESULT_W-1:0];
    end
  end

  assign result_out.valid = out_valid;

endmodule

>>> src/acm_checker.sv
`timescale 1ns / 1ps

module acm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [acm_pkg::RESULT_W-1:0] samples_seen,
  input logic [acm_pkg::RESULT_W-1:0] correct_seen
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // With the output register empty the block always takes input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // The sample count never goes backward between consecutive results.
  a_samples_monotonic: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=>
      (!out_valid || (samples_seen >= $past(samples_seen))))
    else $error("sample count decreased");

  // Correct samples never exceed counted samples.
  a_correct_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (correct_seen <= samples_seen))
    else $error("correct count exceeds sample count");

endmodule

bind argmax_confusion_matrix_top acm_checker u_acm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample_in.valid),
  .in_ready     (sample_in.ready),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .samples_seen (result_out.samples_seen),
  .correct_seen (result_out.correct_seen)
);
